FILE: hdl/dpbm_pkg.sv
// Shared types, constants and helper functions of the detector pixel block mapper.
`timescale 1ns / 1ps
`default_nettype none
package dpbm_pkg;

	localparam int MAX_BLOCKS = 16;
	localparam int MAX_SIDE   = 16;

	localparam int PIX_W  = 12;                  // global pixel index
	localparam int CFG_W  = 5;                   // configuration register
	localparam int CIDX_W = 2;                   // configuration register index
	localparam int NIB_W  = 4;                   // block row/col, local row/col
	localparam int SEQ_W  = $clog2(MAX_BLOCKS);  // table entry index
	localparam int ENT_W  = 2 * NIB_W;           // table entry: row, col
	localparam int SPAN_W = 9;                   // pixels per block row line, up to 256
	localparam int REM_W  = SPAN_W - 1;          // remainder of a division by span
	localparam int CNT_W  = $clog2(PIX_W);       // division step counter
	localparam int GAIN_W = 3;

	localparam logic [CIDX_W-1:0] CFG_PIXELS_PER_SIDE = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_BLOCKS_PER_ROW  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_TABLE_ENTRIES   = 2'd2;

	localparam logic [CFG_W-1:0] RST_PIXELS_PER_SIDE = 5'd8;
	localparam logic [CFG_W-1:0] RST_BLOCKS_PER_ROW  = 5'd1;
	localparam logic [CFG_W-1:0] RST_TABLE_ENTRIES   = 5'd1;

	localparam logic REQ_MAP   = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	localparam logic [GAIN_W-1:0] GAIN_CENTER = 3'd0;
	localparam logic [GAIN_W-1:0] GAIN_INNER  = 3'd1;
	localparam logic [GAIN_W-1:0] GAIN_OUTER  = 3'd2;
	localparam logic [GAIN_W-1:0] GAIN_BESIDE = 3'd3;
	localparam logic [GAIN_W-1:0] GAIN_CORNER = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPAN,
		ST_ROW,
		ST_COL,
		ST_SEARCH,
		ST_FINISH
	} dpbm_state_t;

	typedef struct packed {
		logic              done;
		logic [PIX_W-1:0]  quot;
		logic [REM_W-1:0]  rem;
	} div_res_t;

	typedef struct packed {
		logic              done;
		logic              found;
		logic [SEQ_W-1:0]  seq;
	} srch_res_t;

	// Clamp a register value to 1..hi.
	function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
		input logic [CFG_W-1:0] hi);
		logic [CFG_W-1:0] r;
		begin
			r = v;
			if (v == '0) begin
				r = CFG_W'(1);
			end else if (v > hi) begin
				r = hi;
			end
			return r;
		end
	endfunction

	// Gain group of a pixel at local (r, c) in a block of side n.
	function automatic logic [GAIN_W-1:0] gain_of(input logic [NIB_W-1:0] r,
		input logic [NIB_W-1:0] c, input logic [CFG_W-1:0] n);
		logic signed [6:0] ri, ci, ni;
		logic r_mid, c_mid, r_wide, c_wide, r_edge, c_edge, r_one, c_one;
		logic [GAIN_W-1:0] g;
		begin
			ri = signed'({3'b000, r});
			ci = signed'({3'b000, c});
			ni = signed'({2'b00, n});
			r_mid  = (ri > 7'sd1) && (ri < ni - 7'sd2);
			c_mid  = (ci > 7'sd1) && (ci < ni - 7'sd2);
			r_wide = (ri > 7'sd1) && (ri < ni - 7'sd1);
			c_wide = (ci > 7'sd1) && (ci < ni - 7'sd1);
			r_edge = (ri == 7'sd0) || (ri == ni - 7'sd1);
			c_edge = (ci == 7'sd0) || (ci == ni - 7'sd1);
			r_one  = (ri == 7'sd1) || (ri == ni - 7'sd2);
			c_one  = (ci == 7'sd1) || (ci == ni - 7'sd2);
			if (r_mid && c_mid) begin
				g = GAIN_CENTER;
			end else if ((c_one && r_mid) || (r_one && c_mid)) begin
				g = GAIN_INNER;
			end else if ((c_edge && r_wide) || (r_edge && c_wide)) begin
				g = GAIN_OUTER;
			end else if (c_edge && r_edge) begin
				g = GAIN_CORNER;
			end else begin
				g = GAIN_BESIDE;
			end
			return g;
		end
	endfunction

	// True when two block coordinates differ by at most one (no wrap at the top).
	function automatic logic within_one(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		begin
			return (a == b)
				|| ({1'b0, a} == {1'b0, b} + (PIX_W+1)'(1))
				|| ({1'b0, b} == {1'b0, a} + (PIX_W+1)'(1));
		end
	endfunction

endpackage
`default_nettype wire

FILE: hdl/dpbm_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module dpbm_div
	import dpbm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [PIX_W-1:0]  dividend,
	input  wire logic [SPAN_W-1:0] divisor,
	output div_res_t               res
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PIX_W-1:0]  dvd_q;   // dividend bits out on top, quotient bits in at bottom
	logic [REM_W-1:0]  rem_q;
	logic [SPAN_W-1:0] dsr_q;

	logic [SPAN_W-1:0] trial;
	logic [SPAN_W-1:0] diff;
	logic              take;

	assign trial = {rem_q, dvd_q[PIX_W-1]};
	assign take  = (trial >= dsr_q);
	assign diff  = trial - dsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(PIX_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[PIX_W-2:0], take};
			rem_q <= take ? diff[REM_W-1:0] : trial[REM_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quot = dvd_q;
	assign res.rem  = rem_q;

endmodule
`default_nettype wire

FILE: hdl/dpbm_srch.sv
// Block table storage and serial first-match search, one entry per cycle.
`timescale 1ns / 1ps
`default_nettype none
module dpbm_srch
	import dpbm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [SEQ_W-1:0]  wr_index,
	input  wire logic [NIB_W-1:0]  wr_row,
	input  wire logic [NIB_W-1:0]  wr_col,
	input  wire logic              start,
	input  wire logic [PIX_W-1:0]  brow,
	input  wire logic [NIB_W-1:0]  bcol,
	input  wire logic [CFG_W-1:0]  nent,
	output srch_res_t              res
);

	logic [ENT_W-1:0] table_q [MAX_BLOCKS];
	logic             busy_q;
	logic             done_q;
	logic             found_q;
	logic [SEQ_W-1:0] idx_q;
	logic [SEQ_W-1:0] seq_q;

	logic [ENT_W-1:0] entry;
	logic             hit;
	logic             last;

	assign entry = table_q[idx_q];
	// A block row beyond the nibble range matches no entry.
	assign hit   = (brow[PIX_W-1:NIB_W] == '0) && (entry[ENT_W-1:NIB_W] == brow[NIB_W-1:0])
		&& (entry[NIB_W-1:0] == bcol);
	assign last  = ({1'b0, idx_q} == nent - CFG_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				table_q[i] <= '0;
			end
		end else if (wr_en) begin
			table_q[wr_index] <= {wr_row, wr_col};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				if (hit || last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					idx_q <= idx_q + SEQ_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && (hit || last)) begin
			found_q <= hit;
			seq_q   <= hit ? idx_q : '0;
		end
	end

	assign res.done  = done_q;
	assign res.found = found_q;
	assign res.seq   = seq_q;

endmodule
`default_nettype wire

FILE: hdl/detector_pixel_block_mapper_core.sv
// Top level of the detector pixel block mapper: sequencer, configuration and result register.
`timescale 1ns / 1ps
`default_nettype none
// A map beat (req_type 0) splits pixel_a and pixel_b into block and local coordinates with two
// bit-serial dividers that run side by side and make three passes (pixel by pixels per block
// row, row by side, column by side), each giving 12 quotient bits and then handing the result
// on. The block table is then searched one entry per cycle, up to table_entries entries, and
// then the search ends and the result is loaded into the output register once that is free.
// The time until out_valid rises after a map beat is accepted is set by the divider passes
// and the serial table search. A write beat (req_type 1) stores one table entry, and its
// all-zero result is loaded from ST_FINISH once the output register is free. One beat is
// worked on at a time; in_stall is high from acceptance until the result enters the output
// register, which holds it for the downstream side so the next beat can be taken while it
// waits. The table reads as row 0, column 0 in every entry after reset.
// Configuration writes are taken at any time but belong only to idle periods.
module detector_pixel_block_mapper_core
	import dpbm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration
	input  wire logic              cfg_wr_en,
	input  wire logic [CIDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	// request channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              req_type,
	input  wire logic [PIX_W-1:0]  pixel_a,
	input  wire logic [PIX_W-1:0]  pixel_b,
	input  wire logic [SEQ_W-1:0]  entry_index,
	input  wire logic [NIB_W-1:0]  entry_row,
	input  wire logic [NIB_W-1:0]  entry_col,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   block_found,
	output logic [SEQ_W-1:0]       block_seq,
	output logic [NIB_W-1:0]       local_row,
	output logic [NIB_W-1:0]       local_col,
	output logic [GAIN_W-1:0]      gain_group,
	output logic                   near_block
);

	// configuration registers
	logic [CFG_W-1:0] pps_q, bpr_q, nent_q;
	logic [CFG_W-1:0] side, bpr, nent;
	logic [SPAN_W-1:0] span;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pps_q  <= RST_PIXELS_PER_SIDE;
			bpr_q  <= RST_BLOCKS_PER_ROW;
			nent_q <= RST_TABLE_ENTRIES;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_PIXELS_PER_SIDE: pps_q  <= cfg_data;
				CFG_BLOCKS_PER_ROW:  bpr_q  <= cfg_data;
				CFG_TABLE_ENTRIES:   nent_q <= cfg_data;
				default: ;  // index beyond the list: drop
			endcase
		end
	end

	// clamp to the usable range; span is at most 16 x 16
	assign side = clamp_cfg(pps_q, CFG_W'(MAX_SIDE < 16 ? MAX_SIDE : 16));
	assign bpr  = clamp_cfg(bpr_q, CFG_W'(16));
	assign nent = clamp_cfg(nent_q, CFG_W'(MAX_BLOCKS < 16 ? MAX_BLOCKS : 16));
	assign span = SPAN_W'(side) * SPAN_W'(bpr);

	// sequencer
	dpbm_state_t state_q, state_nx;
	logic        in_acc;
	logic        out_load;
	div_res_t    div_a, div_b;
	srch_res_t   srch;

	assign in_acc   = in_valid && !in_stall;
	assign out_load = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_nx = (req_type == REQ_WRITE) ? ST_FINISH : ST_SPAN;
				end
			end
			ST_SPAN:   if (div_a.done) state_nx = ST_ROW;
			ST_ROW:    if (div_a.done) state_nx = ST_COL;
			ST_COL:    if (div_a.done) state_nx = ST_SEARCH;
			ST_SEARCH: if (srch.done)  state_nx = ST_FINISH;
			ST_FINISH: if (out_load)   state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// per-state controls
	logic              div_start;
	logic              srch_start;
	logic              tbl_wr;
	logic [PIX_W-1:0]  dvd_a, dvd_b;
	logic [SPAN_W-1:0] dsr;
	logic [REM_W-1:0]  gcol_a_q, gcol_b_q;
	logic [PIX_W-1:0]  brow_a_q, brow_b_q;
	logic [NIB_W-1:0]  bcol_a_q, bcol_b_q;
	logic [NIB_W-1:0]  lrow_q, lcol_q;
	logic              wr_q;

	always_comb begin
		div_start  = 1'b0;
		srch_start = 1'b0;
		tbl_wr     = 1'b0;
		in_stall   = 1'b1;
		dvd_a      = pixel_a;
		dvd_b      = pixel_b;
		dsr        = {{(SPAN_W-CFG_W){1'b0}}, side};
		case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				dsr       = span;
				div_start = in_acc && (req_type == REQ_MAP);
				tbl_wr    = in_acc && (req_type == REQ_WRITE);
			end
			ST_SPAN: begin
				// global row goes straight on to the row pass
				dvd_a     = div_a.quot;
				dvd_b     = div_b.quot;
				div_start = div_a.done;
			end
			ST_ROW: begin
				dvd_a     = {{(PIX_W-REM_W){1'b0}}, gcol_a_q};
				dvd_b     = {{(PIX_W-REM_W){1'b0}}, gcol_b_q};
				div_start = div_a.done;
			end
			ST_COL: begin
				srch_start = div_a.done;
			end
			default: ;
		endcase
	end

	dpbm_div u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_a),
		.divisor  (dsr),
		.res      (div_a)
	);

	dpbm_div u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_b),
		.divisor  (dsr),
		.res      (div_b)
	);

	// capture each pass as it finishes
	always_ff @(posedge clk) begin
		if (in_acc) begin
			wr_q <= (req_type == REQ_WRITE);
		end
		if (state_q == ST_SPAN && div_a.done) begin
			gcol_a_q <= div_a.rem;
			gcol_b_q <= div_b.rem;
		end
		if (state_q == ST_ROW && div_a.done) begin
			brow_a_q <= div_a.quot;
			brow_b_q <= div_b.quot;
			lrow_q   <= div_a.rem[NIB_W-1:0];
		end
		if (state_q == ST_COL && div_a.done) begin
			bcol_a_q <= div_a.quot[NIB_W-1:0];
			bcol_b_q <= div_b.quot[NIB_W-1:0];
			lcol_q   <= div_a.rem[NIB_W-1:0];
		end
	end

	dpbm_srch u_srch (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (tbl_wr),
		.wr_index (entry_index),
		.wr_row   (entry_row),
		.wr_col   (entry_col),
		.start    (srch_start),
		.brow     (brow_a_q),
		.bcol     (bcol_a_q),
		.nent     (nent),
		.res      (srch)
	);

	// output register: hold the beat until taken downstream
	logic load;
	assign load = (state_q == ST_FINISH) && out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (wr_q) begin
				// write beat: every field zero
				block_found <= 1'b0;
				block_seq   <= '0;
				local_row   <= '0;
				local_col   <= '0;
				gain_group  <= GAIN_CENTER;
				near_block  <= 1'b0;
			end else begin
				block_found <= srch.found;
				block_seq   <= srch.seq;
				local_row   <= lrow_q;
				local_col   <= lcol_q;
				gain_group  <= gain_of(lrow_q, lcol_q, side);
				near_block  <= within_one(brow_a_q, brow_b_q)
					&& within_one({{(PIX_W-NIB_W){1'b0}}, bcol_a_q},
						{{(PIX_W-NIB_W){1'b0}}, bcol_b_q});
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/dpbm_checker.sv
// Port-level checks of the detector pixel block mapper and their binding.
`timescale 1ns / 1ps
`default_nettype none
module dpbm_checker
	import dpbm_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic              block_found,
	input wire logic [SEQ_W-1:0]  block_seq,
	input wire logic [GAIN_W-1:0] gain_group
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(block_seq) && $stable(gain_group)
			&& $stable(block_found))
		else $error("result changed while stalled");

	// one beat at a time: busy right after an acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second beat taken while busy");

	// a miss reports entry zero
	a_miss_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !block_found |-> block_seq == '0)
		else $error("nonzero entry on a miss");

	// gain group code stays in range
	a_gain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gain_group <= GAIN_CORNER)
		else $error("gain group out of range");

endmodule

bind detector_pixel_block_mapper_core dpbm_checker u_dpbm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.block_found (block_found),
	.block_seq   (block_seq),
	.gain_group  (gain_group)
);
`default_nettype wire

FILE: verif/pixel_map_checker.sv
// Checker of the pixel block mapper: predicts each result from the accepted beats and compares.
`timescale 1ns / 1ps
module pixel_map_checker
	import dpbm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [CIDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic              req_type,
	input  wire logic [PIX_W-1:0]  pixel_a,
	input  wire logic [PIX_W-1:0]  pixel_b,
	input  wire logic [SEQ_W-1:0]  entry_index,
	input  wire logic [NIB_W-1:0]  entry_row,
	input  wire logic [NIB_W-1:0]  entry_col,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic              block_found,
	input  wire logic [SEQ_W-1:0]  block_seq,
	input  wire logic [NIB_W-1:0]  local_row,
	input  wire logic [NIB_W-1:0]  local_col,
	input  wire logic [GAIN_W-1:0] gain_group,
	input  wire logic              near_block,
	output int                     fail_count,
	output int                     results_pending
);

	typedef struct packed {
		logic              found;
		logic [SEQ_W-1:0]  seq;
		logic [NIB_W-1:0]  lrow;
		logic [NIB_W-1:0]  lcol;
		logic [GAIN_W-1:0] gain;
		logic              near;
	} pixel_map_t;

	logic [CFG_W-1:0] side_reg;
	logic [CFG_W-1:0] cols_reg;
	logic [CFG_W-1:0] entries_reg;
	logic [ENT_W-1:0] block_map [MAX_BLOCKS];
	pixel_map_t       expected_maps [$];
	pixel_map_t       oldest;
	int               n;

	initial fail_count = 0;
	initial results_pending = 0;

	function automatic int clip(input int v, input int lo, input int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic [GAIN_W-1:0] gain_class(input int r, input int c, input int s);
		bit r_mid, c_mid, r_wide, c_wide, r_edge, c_edge, r_one, c_one;
		r_mid  = (r > 1) && (r < s - 2);
		c_mid  = (c > 1) && (c < s - 2);
		r_wide = (r > 1) && (r < s - 1);
		c_wide = (c > 1) && (c < s - 1);
		r_edge = (r == 0) || (r == s - 1);
		c_edge = (c == 0) || (c == s - 1);
		r_one  = (r == 1) || (r == s - 2);
		c_one  = (c == 1) || (c == s - 2);
		if (r_mid && c_mid) return GAIN_CENTER;
		if ((c_one && r_mid) || (r_one && c_mid)) return GAIN_INNER;
		if ((c_edge && r_wide) || (r_edge && c_wide)) return GAIN_OUTER;
		if (c_edge && r_edge) return GAIN_CORNER;
		return GAIN_BESIDE;
	endfunction

	// Split both pixels, search the table for pixel a's block, classify its gain.
	function automatic pixel_map_t locate_pixel(input logic [PIX_W-1:0] pa,
		input logic [PIX_W-1:0] pb);
		int side, bpr, nent, span, ia, ib, i;
		int a_brow, a_bcol, a_lrow, a_lcol, b_brow, b_bcol;
		pixel_map_t m;
		side = clip(side_reg, 1, 16);
		if (side > MAX_SIDE) side = MAX_SIDE;
		bpr  = clip(cols_reg, 1, 16);
		nent = clip(entries_reg, 1, 16);
		if (nent > MAX_BLOCKS) nent = MAX_BLOCKS;
		span = bpr * side;
		ia = pa;
		ib = pb;
		a_bcol = (ia % span) / side;
		a_lcol = (ia % span) % side;
		a_brow = (ia / span) / side;
		a_lrow = (ia / span) % side;
		b_bcol = (ib % span) / side;
		b_brow = (ib / span) / side;
		m = '0;
		for (i = 0; i < nent; i++) begin
			if (!m.found && int'(block_map[i][ENT_W-1:NIB_W]) == a_brow
				&& int'(block_map[i][NIB_W-1:0]) == a_bcol) begin
				m.found = 1'b1;
				m.seq   = SEQ_W'(i);
			end
		end
		m.lrow = NIB_W'(a_lrow);
		m.lcol = NIB_W'(a_lcol);
		m.gain = gain_class(a_lrow, a_lcol, side);
		m.near = (a_bcol - b_bcol <= 1) && (b_bcol - a_bcol <= 1)
			&& (a_brow - b_brow <= 1) && (b_brow - a_brow <= 1);
		return m;
	endfunction

	// Append one predicted result behind the ones still outstanding.
	task automatic queue_expected(input pixel_map_t m);
		expected_maps.insert(expected_maps.size(), m);
	endtask

	task automatic check_field(input string label, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_reg    = RST_PIXELS_PER_SIDE;
			cols_reg    = RST_BLOCKS_PER_ROW;
			entries_reg = RST_TABLE_ENTRIES;
			for (n = 0; n < MAX_BLOCKS; n++) block_map[n] = '0;
			expected_maps.delete();
			results_pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_PIXELS_PER_SIDE: side_reg = cfg_data;
					CFG_BLOCKS_PER_ROW:  cols_reg = cfg_data;
					CFG_TABLE_ENTRIES:   entries_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (req_type == REQ_WRITE) begin
					block_map[entry_index] = {entry_row, entry_col};
					queue_expected('0);
				end else begin
					queue_expected(locate_pixel(pixel_a, pixel_b));
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_maps.size() == 0) begin
					$display("%0t: result beat with no expected result", $time);
					fail_count++;
				end else begin
					oldest = expected_maps.pop_front();
					check_field("block_found", oldest.found, block_found);
					check_field("block_seq", oldest.seq, block_seq);
					check_field("local_row", oldest.lrow, local_row);
					check_field("local_col", oldest.lcol, local_col);
					check_field("gain_group", oldest.gain, gain_group);
					check_field("near_block", oldest.near, near_block);
				end
			end
			results_pending <= expected_maps.size();
		end
	end

endmodule

FILE: verif/testbench.sv
// Top of the pixel block mapper testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module testbench;
	import dpbm_pkg::*;

	// unused register index: writes to it must leave every setting alone
	localparam logic [CIDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
	// cycles the receiver holds off in one stretch to back the block up
	localparam int HOLD_CYCLES = 300;
	// cycles without any accepted beat before the run is given up
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PHASES = 10;
	localparam int BEATS_PER_PHASE = 125;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              req_type = REQ_MAP;
	logic [PIX_W-1:0]  pixel_a = '0;
	logic [PIX_W-1:0]  pixel_b = '0;
	logic [SEQ_W-1:0]  entry_index = '0;
	logic [NIB_W-1:0]  entry_row = '0;
	logic [NIB_W-1:0]  entry_col = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              block_found;
	logic [SEQ_W-1:0]  block_seq;
	logic [NIB_W-1:0]  local_row;
	logic [NIB_W-1:0]  local_col;
	logic [GAIN_W-1:0] gain_group;
	logic              near_block;

	int fail_count;
	int results_pending;
	int quiet_cycles = 0;
	int hold_requests = 0;   // raised by the stimulus, served by the receiver
	bit no_idle = 1'b0;      // phase with neither side idling

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	detector_pixel_block_mapper_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.pixel_a    (pixel_a),
		.pixel_b    (pixel_b),
		.entry_index(entry_index),
		.entry_row  (entry_row),
		.entry_col  (entry_col),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.block_found(block_found),
		.block_seq  (block_seq),
		.local_row  (local_row),
		.local_col  (local_col),
		.gain_group (gain_group),
		.near_block (near_block)
	);

	pixel_map_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.pixel_a        (pixel_a),
		.pixel_b        (pixel_b),
		.entry_index    (entry_index),
		.entry_row      (entry_row),
		.entry_col      (entry_col),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.block_found    (block_found),
		.block_seq      (block_seq),
		.local_row      (local_row),
		.local_col      (local_col),
		.gain_group     (gain_group),
		.near_block     (near_block),
		.fail_count     (fail_count),
		.results_pending(results_pending)
	);

	// Idle length: mostly none or short, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Register value for a phase: the clamp extremes often, otherwise in range.
	function automatic logic [CFG_W-1:0] pick_setting();
		case ($urandom_range(0, 9))
			0: return 5'd0;
			1: return 5'd1;
			2: return 5'd16;
			3: return 5'd31;
			default: return CFG_W'($urandom_range(1, 16));
		endcase
	endfunction

	// Table coordinate: mostly small so that pixels land in stored blocks.
	function automatic logic [NIB_W-1:0] rand_nibble();
		if ($urandom_range(0, 3) == 0) return NIB_W'($urandom_range(0, 15));
		return NIB_W'($urandom_range(0, 3));
	endfunction

	// Second pixel: half the time close to the first, so the neighbor test goes both ways.
	function automatic logic [PIX_W-1:0] partner_pixel(input logic [PIX_W-1:0] pa);
		int p;
		if ($urandom_range(0, 1) == 0) return PIX_W'($urandom_range(0, 4095));
		p = int'(pa) + $urandom_range(0, 512) - 256;
		return p[PIX_W-1:0];
	endfunction

	// Offer one beat after an optional gap and hold it until the block takes it.
	// Called at a rising edge; returns at the edge where the beat was accepted.
	task automatic send_beat(input logic req, input logic [PIX_W-1:0] pa,
		input logic [PIX_W-1:0] pb, input logic [SEQ_W-1:0] idx,
		input logic [NIB_W-1:0] row, input logic [NIB_W-1:0] col);
		int gap;
		gap = no_idle ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= req;
		pixel_a     <= pa;
		pixel_b     <= pb;
		entry_index <= idx;
		entry_row   <= row;
		entry_col   <= col;
		do @(posedge clk); while (in_stall);
	endtask

	// Map beat: the table fields carry random noise the block must ignore.
	task automatic map_beat(input logic [PIX_W-1:0] pa, input logic [PIX_W-1:0] pb);
		send_beat(REQ_MAP, pa, pb, SEQ_W'($urandom), NIB_W'($urandom), NIB_W'($urandom));
	endtask

	// Table write beat: the pixel fields carry random noise.
	task automatic store_beat(input logic [SEQ_W-1:0] idx, input logic [NIB_W-1:0] row,
		input logic [NIB_W-1:0] col);
		send_beat(REQ_WRITE, PIX_W'($urandom), PIX_W'($urandom), idx, row, col);
	endtask

	// Drop valid and wait for every expected result, then let the block settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_config(input logic [CFG_W-1:0] side, input logic [CFG_W-1:0] cols,
		input logic [CFG_W-1:0] entries);
		wait_idle();
		write_reg(CFG_PIXELS_PER_SIDE, side);
		write_reg(CFG_BLOCKS_PER_ROW, cols);
		write_reg(CFG_TABLE_ENTRIES, entries);
	endtask

	// Receiver: random stall stretches, none during a no-idle phase, and on request
	// one long hold-off so the block fills up and stalls its input.
	initial begin
		int served;
		int n;
		served = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (served != hold_requests) begin
				served++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (no_idle) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				n = gap_len();
				if (n == 0) begin
					out_stall <= 1'b0;
					@(posedge clk);
				end else begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
					@(posedge clk);
				end
			end
		end
	end

	// Watchdog: give up when no beat moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int ph;
		int k;
		logic [PIX_W-1:0] pa;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings (side 8, one block column, one entry): extreme pixels,
		// alternating bit patterns.
		map_beat(12'd0, 12'hFFF);
		map_beat(12'hFFF, 12'd0);
		map_beat(12'hAAA, 12'h555);
		map_beat(12'h555, 12'hAAA);
		// Fill a few table entries, the top entry with the largest coordinates.
		store_beat(4'd15, 4'd15, 4'd15);
		store_beat(4'd1, 4'd0, 4'd1);
		store_beat(4'd2, 4'd1, 4'd1);

		// Side 8, four block columns (32 pixels per line): walk the gain groups.
		apply_config(5'd8, 5'd4, 5'd16);
		map_beat(12'd99, 12'd4095);   // center, far neighbor
		map_beat(12'd35, 12'd8);      // inner ring
		map_beat(12'd3, 12'd264);     // outer ring
		map_beat(12'd32, 12'd0);      // beside a corner
		map_beat(12'd0, 12'd0);       // corner
		map_beat(12'd264, 12'd8);     // block (1,1), found in entry 2
		map_beat(12'd4095, 12'd3840); // block (15,3): matches no stored entry

		// Zero registers clamp to 1; a write to the unused index changes nothing.
		// With one-pixel blocks the block row reaches past the table range.
		apply_config(5'd0, 5'd0, 5'd0);
		write_reg(CFG_UNUSED_IDX, 5'd31);
		map_beat(12'd0, 12'd4095);
		map_beat(12'd4095, 12'd4094);

		// Registers above range clamp to 16.
		apply_config(5'd31, 5'd31, 5'd31);
		map_beat(12'd4095, 12'd0);
		map_beat(12'd256, 12'd17);

		// Random phases, each under fresh settings.
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			apply_config(pick_setting(), pick_setting(), pick_setting());
			no_idle = (ph == 3);
			// keep offering beats while the receiver holds off
			if (ph == 6) hold_requests++;
			for (k = 0; k < BEATS_PER_PHASE; k++) begin
				if ($urandom_range(0, 4) == 0) begin
					store_beat(SEQ_W'($urandom_range(0, 15)), rand_nibble(), rand_nibble());
				end else begin
					if ($urandom_range(0, 1) == 0) pa = PIX_W'($urandom_range(0, 4095));
					else pa = PIX_W'($urandom_range(0, 1023));
					map_beat(pa, partner_pixel(pa));
				end
			end
		end

		// Drain, then leave room for any stray result beat.
		no_idle = 1'b0;
		wait_idle();
		repeat (60) @(posedge clk);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
